/* hdl/imalu_pkg.sv */
// shared types and constants for the iterative integer alu
`timescale 1ns / 1ps
package imalu_pkg;

    localparam int OPW    = 31;
    localparam int DW     = 32;
    localparam int CNT_W  = 5;

    localparam int DIV_STEPS  = OPW;
    localparam int SQRT_STEPS = DW / 2;

    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

    localparam logic [DW-1:0] SQRT_BIT0 = DW'(1) << (DW - 2);

    typedef enum logic [2:0] {
        CMD_ADD  = 3'd0,
        CMD_SUB  = 3'd1,
        CMD_MUL  = 3'd2,
        CMD_DIV  = 3'd3,
        CMD_SQRT = 3'd4,
        CMD_POW  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_OVF  = 2'd1,
        STAT_DIVZ = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALU,
        S_MUL,
        S_DIV,
        S_SQRT,
        S_PMUL,
        S_PSQ,
        S_DONE
    } state_t;

    typedef struct packed {
        cmd_t           cmd;
        logic [OPW-1:0] operand_a;
        logic [OPW-1:0] operand_b;
    } imalu_req_t;

    typedef struct packed {
        logic signed [DW-1:0] result;
        status_t              status;
    } imalu_rsp_t;

    typedef struct packed {
        logic   load;
        state_t step;
        logic   finish;
    } ctrl_t;

    typedef struct packed {
        logic exp_last;
    } dp_stat_t;

endpackage

/* hdl/imalu_dp.sv */
// datapath: operand registers, shared add/subtract unit and shared multiplier
`timescale 1ns / 1ps
module imalu_dp (
    input  logic                  clk,
    input  imalu_pkg::imalu_req_t request,
    input  imalu_pkg::ctrl_t      ctrl,
    output imalu_pkg::dp_stat_t   stat,
    output imalu_pkg::imalu_rsp_t response
);
    import imalu_pkg::*;

    logic [DW-1:0]   x_reg, x_next;
    logic [DW-1:0]   y_reg, y_next;
    logic [DW-1:0]   z_reg, z_next;
    logic            sub_reg, sub_next;
    logic            acc_big_reg, acc_big_next;
    logic            b_big_reg, b_big_next;
    logic [DW-1:0]   res_reg, res_next;
    status_t         st_reg, st_next;

    logic [DW-1:0]   p_op, q_op;
    logic            sub_op;
    logic [DW:0]     sum;
    logic            ge;
    logic [DW-1:0]   mul_a;
    logic [2*DW-1:0] prod;
    logic            prod_big;

    // shared add/subtract and compare unit
    always_comb
    begin
        p_op   = x_reg;
        q_op   = z_reg;
        sub_op = 1'b1;
        unique case (ctrl.step)
            S_ALU:
            begin
                sub_op = sub_reg;
            end
            S_DIV:
            begin
                p_op = {x_reg[DW-2:0], y_reg[OPW-1]};
            end
            S_SQRT:
            begin
                q_op = y_reg | z_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign sum = {1'b0, p_op} + {1'b0, (sub_op ? ~q_op : q_op)} + {{DW{1'b0}}, sub_op};
    assign ge  = sum[DW];

    // shared multiplier
    assign mul_a    = (ctrl.step == S_PSQ) ? y_reg : x_reg;
    assign prod     = {{DW{1'b0}}, mul_a} * {{DW{1'b0}}, y_reg};
    assign prod_big = |prod[2*DW-1:DW-1];

    always_comb
    begin
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        sub_next     = sub_reg;
        acc_big_next = acc_big_reg;
        b_big_next   = b_big_reg;
        res_next     = res_reg;
        st_next      = st_reg;
        unique case (ctrl.step)
            S_IDLE:
            begin
                if (ctrl.load)
                begin
                    sub_next     = (request.cmd == CMD_SUB);
                    acc_big_next = 1'b0;
                    b_big_next   = 1'b0;
                    res_next     = (request.cmd == CMD_POW) ? DW'(1) : '0;
                    st_next      = (request.cmd == CMD_DIV && request.operand_b == '0)
                                   ? STAT_DIVZ : STAT_OK;
                    unique case (request.cmd)
                        CMD_ADD, CMD_SUB:
                        begin
                            x_next = {1'b0, request.operand_a};
                            z_next = {1'b0, request.operand_b};
                        end
                        CMD_MUL:
                        begin
                            x_next = {1'b0, request.operand_a};
                            y_next = {1'b0, request.operand_b};
                        end
                        CMD_DIV:
                        begin
                            x_next = '0;
                            y_next = {1'b0, request.operand_a};
                            z_next = {1'b0, request.operand_b};
                        end
                        CMD_SQRT:
                        begin
                            x_next = {1'b0, request.operand_a};
                            y_next = '0;
                            z_next = SQRT_BIT0;
                        end
                        CMD_POW:
                        begin
                            x_next = DW'(1);
                            y_next = {1'b0, request.operand_a};
                            z_next = {1'b0, request.operand_b};
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ALU:
            begin
                res_next = sum[DW-1:0];
                st_next  = (!sub_reg && sum[DW-1]) ? STAT_OVF : STAT_OK;
            end
            S_MUL:
            begin
                res_next = prod[DW-1:0];
                st_next  = prod_big ? STAT_OVF : STAT_OK;
            end
            S_DIV:
            begin
                x_next = ge ? sum[DW-1:0] : p_op;
                y_next = {1'b0, y_reg[OPW-2:0], ge};
                if (ctrl.finish)
                begin
                    res_next = y_next;
                    st_next  = STAT_OK;
                end
            end
            S_SQRT:
            begin
                if (ge)
                begin
                    x_next = sum[DW-1:0];
                    y_next = (y_reg >> 1) | z_reg;
                end
                else
                begin
                    y_next = y_reg >> 1;
                end
                z_next = z_reg >> 2;
                if (ctrl.finish)
                begin
                    res_next = y_next;
                    st_next  = STAT_OK;
                end
            end
            S_PMUL:
            begin
                if (z_reg[0])
                begin
                    x_next       = prod[DW-1:0];
                    acc_big_next = acc_big_reg | b_big_reg | prod_big;
                end
                if (ctrl.finish)
                begin
                    res_next = x_next;
                    st_next  = acc_big_next ? STAT_OVF : STAT_OK;
                end
            end
            S_PSQ:
            begin
                y_next     = prod[DW-1:0];
                b_big_next = b_big_reg | prod_big;
                z_next     = z_reg >> 1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        sub_reg     <= sub_next;
        acc_big_reg <= acc_big_next;
        b_big_reg   <= b_big_next;
        res_reg     <= res_next;
        st_reg      <= st_next;
    end

    assign stat.exp_last   = ~|z_reg[DW-1:1];
    assign response.result = res_reg;
    assign response.status = st_reg;

endmodule

/* hdl/imalu_ctrl.sv */
// sequencer: command decode, step counter and handshake state
`timescale 1ns / 1ps
module imalu_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  imalu_pkg::imalu_req_t request,
    input  imalu_pkg::dp_stat_t   stat,
    output imalu_pkg::ctrl_t      ctrl,
    output logic                  busy,
    output logic                  done
);
    import imalu_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             b_zero;

    assign b_zero = (request.operand_b == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ctrl.load   = 1'b0;
        ctrl.step   = state_reg;
        ctrl.finish = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load = 1'b1;
                    unique case (request.cmd)
                        CMD_ADD, CMD_SUB:
                        begin
                            state_next = S_ALU;
                        end
                        CMD_MUL:
                        begin
                            state_next = S_MUL;
                        end
                        CMD_DIV:
                        begin
                            state_next = b_zero ? S_DONE : S_DIV;
                            cnt_next   = DIV_LAST;
                        end
                        CMD_SQRT:
                        begin
                            state_next = S_SQRT;
                            cnt_next   = SQRT_LAST;
                        end
                        CMD_POW:
                        begin
                            state_next = b_zero ? S_DONE : S_PMUL;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ALU, S_MUL:
            begin
                ctrl.finish = 1'b1;
                state_next  = S_DONE;
            end
            S_DIV, S_SQRT:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_PMUL:
            begin
                if (stat.exp_last)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_PSQ;
                end
            end
            S_PSQ:
            begin
                state_next = S_PMUL;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

/* hdl/integer_multicycle_alu_top.sv */
// top level of the iterative integer alu
`timescale 1ns / 1ps
// A command is taken when start is high and busy is low; busy then stays high
// until the result has been shown. The result and status appear on response
// for exactly one cycle with done high and must be captured then, as the
// receiver cannot stall the block. Add and subtract pass through S_ALU and
// multiply through S_MUL before done; divide by zero, zero exponent and
// unused codes go straight to done. Divide takes one quotient bit per cycle
// through the shared 33-bit subtractor, square root one root bit per cycle
// through the same subtractor, and power a multiply step per exponent bit and
// a square step between bits through the single 32x32 multiplier. The next
// command can be taken in the cycle after done.
module integer_multicycle_alu_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  imalu_pkg::imalu_req_t request,
    output logic                  done,
    output imalu_pkg::imalu_rsp_t response
);
    import imalu_pkg::*;

    ctrl_t    ctrl;
    dp_stat_t stat;

    imalu_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .stat    (stat),
        .ctrl    (ctrl),
        .busy    (busy),
        .done    (done)
    );

    imalu_dp u_dp (
        .clk      (clk),
        .request  (request),
        .ctrl     (ctrl),
        .stat     (stat),
        .response (response)
    );

endmodule

/* hdl/imalu_checker.sv */
// port-level checks for the iterative integer alu, bound to the top level
`timescale 1ns / 1ps
module imalu_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input imalu_pkg::imalu_req_t request,
    input logic                  done,
    input imalu_pkg::imalu_rsp_t response
);
    import imalu_pkg::*;

    // a transfer always makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // result strobe only while a command is held
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    // one result per command, then ready again
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("done not followed by idle");

    // divide by zero gives zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && response.status == STAT_DIVZ) |-> (response.result == '0))
        else $error("divide by zero result not zero");

    // only a divide command can end in divide by zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.cmd != CMD_DIV) |=>
            ##1 !(done && response.status == STAT_DIVZ))
        else $error("divide by zero status on other command");

endmodule

bind integer_multicycle_alu_top imalu_checker u_imalu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .response (response)
);

/* tb/tb_integer_multicycle_alu_top.sv */
// self-checking testbench for the iterative integer alu top level
`timescale 1ns / 1ps
module tb_integer_multicycle_alu_top;
    import imalu_pkg::*;

    localparam int              CYCLE_LIMIT  = 1_000_000;
    localparam int              SETTLE_CYCLES = 80;
    localparam logic [2:0]      CMD_UNUSED_6 = 3'd6;
    localparam logic [2:0]      CMD_UNUSED_7 = 3'd7;
    localparam logic [OPW-1:0]  OP_MAX       = '1;
    localparam logic [63:0]     POS_MAX      = 64'h7fff_ffff;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    imalu_req_t request;
    logic       done;
    imalu_rsp_t response;

    imalu_rsp_t awaited_responses[$];
    int         sender_idle_pct;
    int         fail_count;
    int         cycle_count;

    integer_multicycle_alu_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_integer_multicycle_alu_top: errors");
            $finish;
        end
    end

    function automatic logic [31:0] floor_root(input logic [31:0] v);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int i = 15; i >= 0; i--)
        begin
            trial = root | (32'd1 << i);
            if (64'(trial) * 64'(trial) <= 64'(v))
                root = trial;
        end
        return root;
    endfunction

    function automatic imalu_rsp_t compute_response(input imalu_req_t req);
        logic [63:0] wide;
        logic [63:0] acc;
        logic [63:0] sq;
        logic [31:0] e;
        logic [31:0] a;
        logic [31:0] b;
        int          n;
        imalu_rsp_t  rsp;
        a = {1'b0, req.operand_a};
        b = {1'b0, req.operand_b};
        rsp.result = '0;
        rsp.status = STAT_OK;
        case (3'(req.cmd))
            CMD_ADD:
            begin
                wide = 64'(a) + 64'(b);
                rsp.result = wide[31:0];
                if (wide > POS_MAX)
                    rsp.status = STAT_OVF;
            end
            CMD_SUB:
                rsp.result = a - b;
            CMD_MUL:
            begin
                wide = 64'(a) * 64'(b);
                rsp.result = wide[31:0];
                if (wide > POS_MAX)
                    rsp.status = STAT_OVF;
            end
            CMD_DIV:
            begin
                if (b == 0)
                    rsp.status = STAT_DIVZ;
                else
                    rsp.result = a / b;
            end
            CMD_SQRT:
                rsp.result = floor_root(a);
            CMD_POW:
            begin
                acc = 64'd1;
                sq  = 64'(a);
                e   = b;
                while (e != 0)
                begin
                    if (e[0])
                        acc = (acc * sq) & 64'hffff_ffff;
                    sq = (sq * sq) & 64'hffff_ffff;
                    e  = e >> 1;
                end
                rsp.result = acc[31:0];
                // true value check, base of two or more overflows within 31 steps
                if (b != 0 && a > 1)
                begin
                    wide = 64'd1;
                    n    = 0;
                    while (n < b && rsp.status == STAT_OK)
                    begin
                        wide = wide * 64'(a);
                        if (wide > POS_MAX)
                            rsp.status = STAT_OVF;
                        n++;
                    end
                end
            end
            default:
                rsp.result = '0;
        endcase
        return rsp;
    endfunction

    function automatic imalu_req_t make_req(input logic [2:0] code,
                                            input logic [OPW-1:0] a,
                                            input logic [OPW-1:0] b);
        imalu_req_t req;
        req.cmd       = cmd_t'(code);
        req.operand_a = a;
        req.operand_b = b;
        return req;
    endfunction

    function automatic logic [OPW-1:0] rand_operand();
        case ($urandom_range(9))
            0: return '0;
            1: return OP_MAX;
            2: return OPW'($urandom_range(15));
            3: return OPW'(1) << $urandom_range(OPW - 1);
            4: return (OPW'(1) << $urandom_range(OPW - 1)) - OPW'(1);
            default: return OPW'($urandom);
        endcase
    endfunction

    function automatic imalu_req_t random_request();
        logic [2:0]     code;
        logic [OPW-1:0] a;
        logic [OPW-1:0] b;
        logic [31:0]    k;
        if ($urandom_range(99) < 4)
            code = $urandom_range(1) ? CMD_UNUSED_7 : CMD_UNUSED_6;
        else
            code = 3'($urandom_range(5));
        a = rand_operand();
        b = rand_operand();
        case (code)
            CMD_DIV:
            begin
                case ($urandom_range(9))
                    0: b = '0;
                    1, 2, 3: b = OPW'($urandom_range(1, 1000));
                    default: b = rand_operand();
                endcase
            end
            CMD_SQRT:
            begin
                if ($urandom_range(2) == 0)
                begin
                    k = $urandom_range(46340);
                    a = OPW'(k * k) + OPW'($urandom_range(2)) - OPW'(k != 0);
                end
            end
            CMD_POW:
            begin
                if ($urandom_range(9) < 4)
                    a = OPW'($urandom_range(12));
                case ($urandom_range(9))
                    0, 1: b = OPW'($urandom_range(3));
                    2, 3, 4, 5, 6: b = OPW'($urandom_range(33));
                    default: b = rand_operand();
                endcase
            end
            default:
            begin
            end
        endcase
        return make_req(code, a, b);
    endfunction

    // one command transfer, with random idle cycles ahead of it
    task automatic send_cmd(input imalu_req_t req);
        @(negedge clk);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        awaited_responses.push_back(compute_response(req));
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        start <= 1'b0;
        while (awaited_responses.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        imalu_rsp_t want;
        if (rst_n && done)
        begin
            if (awaited_responses.size() == 0)
            begin
                $error("result transfer with nothing outstanding: result %0d, status %0d",
                       response.result, response.status);
                fail_count++;
            end
            else
            begin
                want = awaited_responses.pop_front();
                if (response.result !== want.result)
                begin
                    $error("result: expected %0d, got %0d", want.result, response.result);
                    fail_count++;
                end
                if (response.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, response.status);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_corner_cases();
        sender_idle_pct = 0;
        send_cmd(make_req(CMD_ADD, '0, '0));
        send_cmd(make_req(CMD_ADD, OP_MAX, OP_MAX));
        send_cmd(make_req(CMD_ADD, OP_MAX, '0));
        send_cmd(make_req(CMD_ADD, OPW'(1) << 30, OPW'(1) << 30));
        send_cmd(make_req(CMD_SUB, '0, OP_MAX));
        send_cmd(make_req(CMD_SUB, OP_MAX, '0));
        send_cmd(make_req(CMD_MUL, OP_MAX, OP_MAX));
        send_cmd(make_req(CMD_MUL, OPW'(46340), OPW'(46340)));
        send_cmd(make_req(CMD_MUL, OPW'(46341), OPW'(46341)));
        send_cmd(make_req(CMD_MUL, '0, OP_MAX));
        send_cmd(make_req(CMD_DIV, OP_MAX, OPW'(1)));
        send_cmd(make_req(CMD_DIV, OPW'(7), '0));
        send_cmd(make_req(CMD_DIV, '0, '0));
        send_cmd(make_req(CMD_DIV, OPW'(5), OP_MAX));
        send_cmd(make_req(CMD_SQRT, '0, OP_MAX));
        send_cmd(make_req(CMD_SQRT, OPW'(1), '0));
        send_cmd(make_req(CMD_SQRT, OPW'(16), '0));
        send_cmd(make_req(CMD_SQRT, OPW'(15), '0));
        send_cmd(make_req(CMD_SQRT, OP_MAX, '0));
        send_cmd(make_req(CMD_POW, '0, '0));
        send_cmd(make_req(CMD_POW, '0, OPW'(5)));
        send_cmd(make_req(CMD_POW, OPW'(1), OP_MAX));
        send_cmd(make_req(CMD_POW, OPW'(2), OPW'(30)));
        send_cmd(make_req(CMD_POW, OPW'(2), OPW'(31)));
        send_cmd(make_req(CMD_POW, OP_MAX, OP_MAX));
        send_cmd(make_req(CMD_UNUSED_6, OP_MAX, OP_MAX));
        send_cmd(make_req(CMD_UNUSED_7, OPW'(3), OPW'(9)));
    endtask

    task automatic test_random_ops(input int count, input int idle_pct);
        sender_idle_pct = idle_pct;
        for (int i = 0; i < count; i++)
            send_cmd(random_request());
    endtask

    // block drained of results before every transfer
    task automatic test_drained_restart(input int count);
        sender_idle_pct = 0;
        for (int i = 0; i < count; i++)
        begin
            wait_all_results();
            send_cmd(random_request());
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        request         = '0;
        sender_idle_pct = 0;
        fail_count      = 0;
        cycle_count     = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_corner_cases();
        test_random_ops(400, 0);
        test_random_ops(450, 72);
        wait_all_results();
        test_random_ops(450, 18);
        test_drained_restart(20);

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_integer_multicycle_alu_top: clean");
        else
            $display("tb_integer_multicycle_alu_top: errors");
        $finish;
    end

endmodule
